>>> rtl/bit_timed_uart_8n1_unit_assert.svh
// Assertion macros for the bit-timed UART unit.
// Expects clk and rst in the scope of the module that uses them.
`ifndef BIT_TIMED_UART_8N1_UNIT_ASSERT_SVH
`define BIT_TIMED_UART_8N1_UNIT_ASSERT_SVH

// check a property on every clock edge outside reset
`define BTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition implies a next-cycle consequence
`define BTU_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

>>> rtl/btu_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the bit-timed UART unit.
// No dependencies.
package btu_pkg;

  localparam int unsigned DataBits   = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned BitIdxW    = 3;
  localparam logic [TimerW-1:0] PeriodReset = 16'd104;

endpackage

>>> rtl/btu_sample_if.sv
`timescale 1ns / 1ps
// Input channel of the bit-timed UART unit: one line sample per transaction.
// Depends on btu_pkg.
interface btu_sample_if;
  logic                       valid;
  logic                       ready;
  logic                       rx_line;
  logic                       send_valid;
  logic [btu_pkg::ByteW-1:0]  send_byte;
  logic                       read_ack;

  modport source (output valid, rx_line, send_valid, send_byte, read_ack, input ready);
  modport sink   (input valid, rx_line, send_valid, send_byte, read_ack, output ready);
endinterface

>>> rtl/btu_result_if.sv
`timescale 1ns / 1ps
// Output channel of the bit-timed UART unit: line and status per transaction.
// Depends on btu_pkg.
interface btu_result_if;
  logic                       valid;
  logic                       ready;
  logic                       tx_line;
  logic                       tx_done;
  logic                       rx_ready;
  logic [btu_pkg::ByteW-1:0]  rx_data;

  modport source (output valid, tx_line, tx_done, rx_ready, rx_data, input ready);
  modport sink   (input valid, tx_line, tx_done, rx_ready, rx_data, output ready);
endinterface

>>> rtl/bit_timed_uart_8n1_unit.sv
`timescale 1ns / 1ps
// Bit-timed UART transmitter and receiver, one line sample per transaction.
// Depends on btu_pkg, btu_sample_if, btu_result_if and the assertion header.
//
//   channel   | dir | fields                                   | handshake
//   samples   | in  | rx_line, send_valid, send_byte, read_ack | valid/ready
//   results   | out | tx_line, tx_done, rx_ready, rx_data      | valid/ready
//   cfg       | in  | cfg_wdata (bit_period)                   | cfg_we
//
// One transaction per cycle while samples.ready is high: state updates in the
// accepting cycle, the result register shows it from the next cycle on.
// samples.ready is low only while a result waits and results.ready is low.
// rst is synchronous: bit period returns to 104, both line sides go idle.
`include "bit_timed_uart_8n1_unit_assert.svh"

module bit_timed_uart_8n1_unit (
  input  logic                          clk,
  input  logic                          rst,
  btu_sample_if.sink                    samples,
  btu_result_if.source                  results,
  input  logic                          cfg_we,
  input  logic [btu_pkg::TimerW-1:0]    cfg_wdata
);

  logic [btu_pkg::TimerW-1:0]  bit_period;

  logic [btu_pkg::ByteW-1:0]   tx_shift, tx_shift_next;
  logic [btu_pkg::CountW-1:0]  tx_bit_count, tx_bit_count_next;
  logic                        tx_active, tx_active_next;
  logic [btu_pkg::TimerW-1:0]  tx_cycles, tx_cycles_next;
  logic                        tx_level, tx_level_next;
  logic                        tx_finished, tx_finished_next;
  logic [btu_pkg::ByteW-1:0]   rx_shift, rx_shift_next;
  logic [btu_pkg::CountW-1:0]  rx_bit_count, rx_bit_count_next;
  logic                        rx_active, rx_active_next;
  logic [btu_pkg::TimerW-1:0]  rx_cycles, rx_cycles_next;
  logic                        rx_full, rx_full_next;
  logic                        rx_previous_level;

  logic                        res_valid;
  logic                        accept;
  logic [btu_pkg::TimerW-1:0]  period_len;
  logic [btu_pkg::TimerW:0]    tx_cycles_inc, rx_cycles_inc;
  logic                        tx_tick, rx_tick;

  localparam logic [btu_pkg::CountW-1:0] DataBitsC = btu_pkg::CountW'(btu_pkg::DataBits);
  localparam logic [btu_pkg::CountW-1:0] ByteBitsC = btu_pkg::CountW'(btu_pkg::ByteW);

  assign samples.ready = !res_valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  assign period_len    = (bit_period == '0) ? btu_pkg::TimerW'(1) : bit_period;
  assign tx_cycles_inc = {1'b0, tx_cycles} + 1'b1;
  assign rx_cycles_inc = {1'b0, rx_cycles} + 1'b1;
  assign tx_tick       = tx_cycles_inc >= {1'b0, period_len};
  assign rx_tick       = rx_cycles_inc >= {1'b0, period_len};

  always_comb begin
    tx_shift_next     = tx_shift;
    tx_bit_count_next = tx_bit_count;
    tx_active_next    = tx_active;
    tx_cycles_next    = tx_cycles;
    tx_level_next     = tx_level;
    tx_finished_next  = tx_finished;
    if (!tx_active) begin
      if (samples.send_valid) begin
        tx_shift_next     = samples.send_byte;
        tx_finished_next  = 1'b0;
        tx_level_next     = 1'b0;
        tx_active_next    = 1'b1;
        tx_cycles_next    = '0;
        tx_bit_count_next = '0;
      end
    end else begin
      tx_cycles_next = tx_tick ? '0 : tx_cycles_inc[btu_pkg::TimerW-1:0];
      if (tx_tick) begin
        if (tx_bit_count < DataBitsC) begin
          tx_level_next     = tx_shift[0];
          tx_shift_next     = {1'b0, tx_shift[btu_pkg::ByteW-1:1]};
          tx_bit_count_next = tx_bit_count + 1'b1;
        end else if (tx_bit_count == DataBitsC) begin
          tx_level_next     = 1'b1;
          tx_bit_count_next = tx_bit_count + 1'b1;
        end else begin
          tx_bit_count_next = '0;
          tx_shift_next     = '0;
          tx_finished_next  = 1'b1;
          tx_active_next    = 1'b0;
        end
      end
    end
  end

  always_comb begin
    rx_shift_next     = samples.read_ack ? '0 : rx_shift;
    rx_full_next      = samples.read_ack ? 1'b0 : rx_full;
    rx_bit_count_next = rx_bit_count;
    rx_active_next    = rx_active;
    rx_cycles_next    = rx_cycles;
    if (!rx_active) begin
      if (rx_previous_level && !samples.rx_line) begin
        rx_active_next    = 1'b1;
        rx_cycles_next    = '0;
        rx_bit_count_next = '0;
      end
    end else begin
      rx_cycles_next = rx_tick ? '0 : rx_cycles_inc[btu_pkg::TimerW-1:0];
      if (rx_tick) begin
        if (rx_bit_count >= DataBitsC) begin
          if (samples.rx_line) begin
            rx_bit_count_next = '0;
            rx_full_next      = 1'b1;
            rx_active_next    = 1'b0;
          end
        end else begin
          if (rx_bit_count < ByteBitsC) begin
            rx_shift_next[rx_bit_count[btu_pkg::BitIdxW-1:0]] =
              rx_shift_next[rx_bit_count[btu_pkg::BitIdxW-1:0]] | samples.rx_line;
          end
          rx_bit_count_next = rx_bit_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= btu_pkg::PeriodReset;
    end else if (cfg_we) begin
      bit_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift          <= '0;
      tx_bit_count      <= '0;
      tx_active         <= 1'b0;
      tx_cycles         <= '0;
      tx_level          <= 1'b1;
      tx_finished       <= 1'b1;
      rx_shift          <= '0;
      rx_bit_count      <= '0;
      rx_active         <= 1'b0;
      rx_cycles         <= '0;
      rx_full           <= 1'b0;
      rx_previous_level <= 1'b1;
    end else if (accept) begin
      tx_shift          <= tx_shift_next;
      tx_bit_count      <= tx_bit_count_next;
      tx_active         <= tx_active_next;
      tx_cycles         <= tx_cycles_next;
      tx_level          <= tx_level_next;
      tx_finished       <= tx_finished_next;
      rx_shift          <= rx_shift_next;
      rx_bit_count      <= rx_bit_count_next;
      rx_active         <= rx_active_next;
      rx_cycles         <= rx_cycles_next;
      rx_full           <= rx_full_next;
      rx_previous_level <= samples.rx_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.tx_line  <= tx_level_next;
      results.tx_done  <= tx_finished_next;
      results.rx_ready <= rx_full_next;
      results.rx_data  <= rx_shift_next;
    end
  end

  assign results.valid = res_valid;

  `BTU_ASSERT(a_tx_idle_high, !tx_active |-> (tx_level && tx_bit_count == '0), "tx idle not high")
  `BTU_ASSERT(a_tx_done_excl, !(tx_active && tx_finished), "tx busy and done together")
  `BTU_ASSERT(a_rx_count_range, rx_bit_count <= DataBitsC, "rx bit count out of range")
  `BTU_ASSERT_NEXT(a_hold_state, !rst && !accept, $stable(tx_shift) && $stable(rx_shift) && $stable(tx_cycles), "state moved without a transaction")

endmodule

>>> dv/bit_timed_uart_8n1_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bit_timed_uart_8n1_unit: serial frames, sends and
// read acknowledges go in one sample per transaction, each status is predicted and compared.
// Depends on btu_pkg, btu_sample_if, btu_result_if and the unit itself.
module bit_timed_uart_8n1_unit_tb;

  typedef struct packed {
    logic                       tx_line;
    logic                       tx_done;
    logic                       rx_ready;
    logic [btu_pkg::ByteW-1:0]  rx_data;
  } line_status_t;

  typedef struct packed {
    logic [btu_pkg::ByteW-1:0]   tx_shift;
    logic [btu_pkg::CountW-1:0]  tx_count;
    logic                        tx_busy;
    logic [btu_pkg::TimerW-1:0]  tx_cycles;
    logic                        tx_level;
    logic                        tx_done;
    logic [btu_pkg::ByteW-1:0]   rx_shift;
    logic [btu_pkg::CountW-1:0]  rx_count;
    logic                        rx_busy;
    logic [btu_pkg::TimerW-1:0]  rx_cycles;
    logic                        rx_full;
    logic                        rx_prev;
  } uart_state_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [btu_pkg::TimerW-1:0]   cfg_wdata;

  btu_sample_if samples_if ();
  btu_result_if results_if ();

  bit_timed_uart_8n1_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  uart_state_t                  line_model;
  logic [btu_pkg::TimerW-1:0]   bit_period;
  line_status_t                 status_q[$];

  int samples_taken;
  int statuses_checked;
  int errors;
  int frames_sent;
  int periods_used;
  int items_offered;
  int burst_left;
  int stall_pct;
  int send_pct;
  int ack_pct;
  int holdoff_cycles;
  bit gaps_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit period_end(input logic [btu_pkg::TimerW-1:0] timer);
    int len;
    len = (bit_period == '0) ? 1 : int'(bit_period);
    return (int'(timer) + 1) >= len;
  endfunction

  // one accepted sample of the line model; returns the status shown after the update
  function automatic line_status_t uart_cycle(input logic rx, input logic sv,
                                              input logic [btu_pkg::ByteW-1:0] sb,
                                              input logic ra);
    line_status_t st;
    if (!line_model.tx_busy) begin
      if (sv) begin
        line_model.tx_shift  = sb;
        line_model.tx_done   = 1'b0;
        line_model.tx_level  = 1'b0;
        line_model.tx_busy   = 1'b1;
        line_model.tx_cycles = '0;
        line_model.tx_count  = '0;
      end
    end else if (period_end(line_model.tx_cycles)) begin
      line_model.tx_cycles = '0;
      if (line_model.tx_count < btu_pkg::DataBits) begin
        line_model.tx_level = line_model.tx_shift[0];
        line_model.tx_shift = line_model.tx_shift >> 1;
        line_model.tx_count = line_model.tx_count + 1'b1;
      end else if (line_model.tx_count == btu_pkg::DataBits) begin
        line_model.tx_level = 1'b1;
        line_model.tx_count = line_model.tx_count + 1'b1;
      end else begin
        line_model.tx_count = '0;
        line_model.tx_shift = '0;
        line_model.tx_done  = 1'b1;
        line_model.tx_busy  = 1'b0;
      end
    end else begin
      line_model.tx_cycles = line_model.tx_cycles + 1'b1;
    end

    if (ra) begin
      line_model.rx_shift = '0;
      line_model.rx_full  = 1'b0;
    end
    if (!line_model.rx_busy) begin
      if (line_model.rx_prev && !rx) begin
        line_model.rx_busy   = 1'b1;
        line_model.rx_cycles = '0;
        line_model.rx_count  = '0;
      end
    end else if (period_end(line_model.rx_cycles)) begin
      line_model.rx_cycles = '0;
      if (line_model.rx_count >= btu_pkg::DataBits) begin
        if (rx) begin
          line_model.rx_count = '0;
          line_model.rx_full  = 1'b1;
          line_model.rx_busy  = 1'b0;
        end
      end else begin
        line_model.rx_shift = line_model.rx_shift |
                              (btu_pkg::ByteW'(rx) << line_model.rx_count);
        line_model.rx_count = line_model.rx_count + 1'b1;
      end
    end else begin
      line_model.rx_cycles = line_model.rx_cycles + 1'b1;
    end
    line_model.rx_prev = rx;

    st.tx_line  = line_model.tx_level;
    st.tx_done  = line_model.tx_done;
    st.rx_ready = line_model.rx_full;
    st.rx_data  = line_model.rx_shift;
    return st;
  endfunction

  always @(posedge clk) begin : predict_status
    if (!rst && samples_if.valid && samples_if.ready) begin
      status_q.push_back(uart_cycle(samples_if.rx_line, samples_if.send_valid,
                                    samples_if.send_byte, samples_if.read_ack));
      samples_taken++;
    end
  end

  always @(posedge clk) begin : check_status
    line_status_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected status: tx=%0b done=%0b rdy=%0b data=%02h",
                   results_if.tx_line, results_if.tx_done, results_if.rx_ready,
                   results_if.rx_data);
      end else begin
        want = status_q.pop_front();
        statuses_checked++;
        if (results_if.tx_line !== want.tx_line || results_if.tx_done !== want.tx_done ||
            results_if.rx_ready !== want.rx_ready || results_if.rx_data !== want.rx_data) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: exp %0b %0b %0b %02h got %0b %0b %0b %02h",
                     $realtime, want.tx_line, want.tx_done, want.rx_ready, want.rx_data,
                     results_if.tx_line, results_if.tx_done, results_if.rx_ready,
                     results_if.rx_data);
        end
      end
    end
  end

  initial begin : status_sink
    int  run_left;
    int  hold;
    bit  level;
    results_if.ready <= 1'b0;
    run_left = 0;
    level    = 1'b1;
    forever begin
      @(posedge clk);
      if (holdoff_cycles > 0) begin
        hold = holdoff_cycles;
        holdoff_cycles = 0;
        results_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          if (stall_pct == 0 || !chance(stall_pct)) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 24);
          end else begin
            level    = 1'b0;
            run_left = $urandom_range(1, 6);
          end
        end
        run_left--;
        results_if.ready <= level;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout: stimulus or status transactions stalled");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic rx, input logic sv,
                             input logic [btu_pkg::ByteW-1:0] sb, input logic ra);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = gaps_on ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    samples_if.valid      <= 1'b1;
    samples_if.rx_line    <= rx;
    samples_if.send_valid <= sv;
    samples_if.send_byte  <= sb;
    samples_if.read_ack   <= ra;
    items_offered++;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_status();
    samples_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (status_q.size() != 0 || results_if.valid) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_bit_period(input logic [btu_pkg::TimerW-1:0] value);
    drain_status();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bit_period = value;
    periods_used++;
  endtask

  task automatic send_idle(input int n);
    repeat (n) send_sample(1'b1, chance(send_pct), btu_pkg::ByteW'($urandom_range(0, 255)),
                           chance(ack_pct));
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_sample(logic'($urandom_range(0, 1)), chance(send_pct),
                           btu_pkg::ByteW'($urandom_range(0, 255)), chance(ack_pct));
  endtask

  // start bit, data LSB first, stop bit; each bit held for one bit period of samples
  task automatic send_frame(input logic [btu_pkg::ByteW-1:0] data, input bit stop_high,
                            input bit ack_on_stop);
    int   len;
    logic level;
    len = (bit_period == '0) ? 1 : int'(bit_period);
    for (int b = 0; b < btu_pkg::DataBits + 2; b++) begin
      level = (b == 0) ? 1'b0 : (b <= btu_pkg::DataBits) ? data[b-1] : logic'(stop_high);
      for (int k = 0; k < len; k++)
        send_sample(level, chance(send_pct), btu_pkg::ByteW'($urandom_range(0, 255)),
                    (ack_on_stop && b == btu_pkg::DataBits + 1 && k == 0) ||
                    chance(ack_pct));
    end
    frames_sent++;
  endtask

  task automatic test_reset_period();
    send_sample(1'b1, 1'b1, 8'hA5, 1'b0);
    send_sample(1'b0, 1'b1, 8'h5A, 1'b0);
    repeat (10) send_sample(1'b0, 1'b0, 8'h00, 1'b0);
    send_sample(1'b1, 1'b0, 8'hFF, 1'b1);
  endtask

  task automatic test_special_cases();
    send_pct = 0;
    ack_pct  = 0;
    set_bit_period(16'd0);
    send_sample(1'b1, 1'b1, 8'hFF, 1'b0);
    send_frame(8'h00, 1'b1, 1'b0);
    set_bit_period(16'd1);
    send_sample(1'b1, 1'b1, 8'h00, 1'b0);
    send_frame(8'hFF, 1'b1, 1'b0);
    send_frame(8'h55, 1'b1, 1'b0);
    send_frame(8'h81, 1'b0, 1'b0);
    send_idle(2);
    send_frame(8'hA5, 1'b1, 1'b1);
    send_sample(1'b1, 1'b0, 8'h00, 1'b1);
  endtask

  task automatic test_long_period();
    gaps_on   = 1'b0;
    stall_pct = 0;
    send_pct  = 0;
    ack_pct   = 0;
    set_bit_period(16'hFFFF);
    send_sample(1'b1, 1'b1, 8'hC3, 1'b0);
    for (int i = 0; i < 48; i++)
      send_sample(logic'(i == 0 || i >= 24), 1'b0, 8'h00, 1'b0);
    set_bit_period(16'd1);
    send_idle(12);
    gaps_on   = 1'b1;
    stall_pct = 25;
  endtask

  task automatic test_random_traffic();
    logic [btu_pkg::TimerW-1:0] periods[7] = '{16'd2, 16'd3, 16'd1, 16'd5, 16'd0, 16'd7,
                                               16'd4};
    int target;
    int pick;
    send_pct = 12;
    ack_pct  = 3;
    foreach (periods[i]) begin
      set_bit_period(periods[i]);
      target = items_offered + 130;
      while (items_offered < target) begin
        send_idle($urandom_range(1, 3));
        pick = $urandom_range(0, 99);
        if (pick < 82)
          send_frame(btu_pkg::ByteW'($urandom_range(0, 255)), chance(90), chance(5));
        else
          send_noise($urandom_range(4, 24));
      end
    end
  endtask

  task automatic test_backpressure();
    set_bit_period(16'd3);
    holdoff_cycles = 300;
    repeat (4) begin
      send_idle(2);
      send_frame(btu_pkg::ByteW'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endtask

  initial begin : run_tests
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    samples_if.valid      <= 1'b0;
    samples_if.rx_line    <= 1'b1;
    samples_if.send_valid <= 1'b0;
    samples_if.send_byte  <= '0;
    samples_if.read_ack   <= 1'b0;
    line_model          = '0;
    line_model.tx_level = 1'b1;
    line_model.tx_done  = 1'b1;
    line_model.rx_prev  = 1'b1;
    bit_period          = btu_pkg::PeriodReset;
    gaps_on        = 1'b1;
    stall_pct      = 25;
    send_pct       = 0;
    ack_pct        = 0;
    holdoff_cycles = 0;
    burst_left     = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_period();
    test_special_cases();
    test_random_traffic();
    test_backpressure();
    test_long_period();
    drain_status();

    $display("Ran %0d line samples and checked %0d status transactions over %0d period writes,",
             samples_taken, statuses_checked, periods_used);
    $display("with %0d serial frames, a long result-side stall and a 65535-cycle bit period.",
             frames_sent);
    if (errors == 0 && status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d status transactions missing", errors, status_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
